// ----- rtl/psor_pkg.sv -----
`timescale 1ns / 1ps
package psor_pkg;

  localparam logic [1:0] OP_WRITE  = 2'd0;
  localparam logic [1:0] OP_SOLVE  = 2'd1;
  localparam logic [1:0] OP_READ   = 2'd2;

  localparam logic [1:0] REG_RELAX  = 2'd0;
  localparam logic [1:0] REG_SWEEPS = 2'd1;
  localparam logic [1:0] REG_GAIN   = 2'd2;

  localparam logic [14:0]        RELAX_RESET  = 15'd30204;
  localparam logic [7:0]         SWEEPS_RESET = 8'd40;
  localparam logic signed [31:0] GAIN_RESET   = 32'sd331200;

  localparam int RELAX_SHIFT  = 14;
  localparam int SOURCE_SHIFT = 24;
  localparam int DIV_BITS     = 7;
  localparam int DIV_STEPS    = 5;

  // neighbour read order, centre last
  localparam logic [2:0] NB_XP   = 3'd0;
  localparam logic [2:0] NB_XM   = 3'd1;
  localparam logic [2:0] NB_YP   = 3'd2;
  localparam logic [2:0] NB_YM   = 3'd3;
  localparam logic [2:0] NB_ZP   = 3'd4;
  localparam logic [2:0] NB_ZM   = 3'd5;
  localparam logic [2:0] NB_C    = 3'd6;
  localparam logic [2:0] NB_LAST = 3'd7;

  function automatic logic signed [31:0] sat32(input logic signed [63:0] v);
    logic signed [31:0] r;
    if (!v[63] && (|v[62:31])) begin
      r = 32'sh7FFF_FFFF;
    end else if (v[63] && !(&v[62:31])) begin
      r = 32'sh8000_0000;
    end else begin
      r = v[31:0];
    end
    return r;
  endfunction

endpackage

// ----- rtl/psor_ram.sv -----
`timescale 1ns / 1ps
module psor_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/poisson_sor_solver_3d.sv -----
`timescale 1ns / 1ps
// Poisson solver over a GRID_X x GRID_Y x GRID_Z grid, SOR on a 7-point stencil.
// Input channel (in_valid_i / in_stall_o) takes one item: write a cell's source
// term from its densities, run a solve, or read a cell's potential. Each item
// gives one result item on the output channel (out_valid_o / out_stall_i).
// Registers relax_factor, sweep_count and source_gain are written through the
// cfg port (cfg_valid_i / cfg_ready_o, index 0..2); ready is always high.
// After reset both grids are cleared one cell a cycle, GRID_X*GRID_Y*GRID_Z
// cells (65536 at defaults); no item is taken until the clear is done.
// A write steps through S_WR1, S_WR2 and S_WR3, a read through S_RD and S_RDW;
// a wall or outside write gives its result with no further state. A solve runs
// sweep_count sweeps over z = 1..GRID_Z-2; per cell it reads seven potentials
// one at a time through the single read port of the potential memory, divides
// the neighbour sum by six seven bits a cycle, then multiplies and writes back.
// One item is processed at a time; the next is taken once the result item has
// left the output register. While out_stall_i is high the result holds and the
// input channel stalls.
module poisson_sor_solver_3d
  import psor_pkg::*;
#(
  parameter int GRID_X = 32,
  parameter int GRID_Y = 32,
  parameter int GRID_Z = 64
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [1:0]         operation_i,
  input  logic [4:0]         pos_x_i,
  input  logic [4:0]         pos_y_i,
  input  logic [5:0]         pos_z_i,
  input  logic [31:0]        electron_density_i,
  input  logic [31:0]        ion_density_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic signed [31:0] potential_o,
  output logic               status_o,
  input  logic               cfg_valid_i,
  output logic               cfg_ready_o,
  input  logic [1:0]         cfg_index_i,
  input  logic [31:0]        cfg_data_i
);

  localparam int XW    = $clog2(GRID_X);
  localparam int YW    = $clog2(GRID_Y);
  localparam int ZW    = $clog2(GRID_Z);
  localparam int PLANE = GRID_X * GRID_Y;
  localparam int CELLS = PLANE * GRID_Z;
  localparam int AW    = $clog2(CELLS);

  localparam logic [3:0] S_CLEAR = 4'd0;
  localparam logic [3:0] S_IDLE  = 4'd1;
  localparam logic [3:0] S_WR1   = 4'd2;
  localparam logic [3:0] S_WR2   = 4'd3;
  localparam logic [3:0] S_WR3   = 4'd4;
  localparam logic [3:0] S_RD    = 4'd5;
  localparam logic [3:0] S_RDW   = 4'd6;
  localparam logic [3:0] S_SRD   = 4'd7;
  localparam logic [3:0] S_DIV   = 4'd8;
  localparam logic [3:0] S_MUL   = 4'd9;
  localparam logic [3:0] S_UPD   = 4'd10;

  function automatic logic [AW-1:0] cell_addr(input logic [ZW-1:0] z,
                                               input logic [XW-1:0] x,
                                               input logic [YW-1:0] y);
    return AW'(AW'(z) * AW'(PLANE) + AW'(x) * AW'(GRID_Y) + AW'(y));
  endfunction

  logic [3:0]         state_q, state_d;
  logic [AW-1:0]      clr_q;
  logic [14:0]        relax_q;
  logic [7:0]         sweeps_q;
  logic signed [31:0] gain_q;

  logic               out_valid_q;
  logic signed [31:0] pot_out_q;
  logic               status_q;

  logic [AW-1:0]      req_addr_q;
  logic signed [32:0] diff_q;
  logic signed [64:0] prodw_q;

  logic [7:0]         sweep_q;
  logic [ZW-1:0]      z_q;
  logic [XW-1:0]      x_q;
  logic [YW-1:0]      y_q;
  logic [2:0]         nb_q;
  logic signed [34:0] sum_q;
  logic signed [31:0] v_q;
  logic signed [31:0] s_q;
  logic [34:0]        div_q;
  logic [2:0]         rem_q;
  logic [2:0]         dstep_q;
  logic signed [49:0] prod_q;

  logic               in_acc;
  logic               in_grid;
  logic               wall;
  logic [XW-1:0]      xp, xm;
  logic [YW-1:0]      yp, ym;
  logic [AW-1:0]      centre_addr;
  logic [AW-1:0]      nb_addr;
  logic [34:0]        div_d;
  logic [2:0]         rem_d;
  logic signed [31:0] avg;
  logic signed [33:0] resid;
  logic signed [31:0] new_v;

  logic               pot_we, src_we;
  logic [AW-1:0]      pot_waddr, src_waddr, pot_raddr;
  logic [31:0]        pot_wdata, src_wdata, pot_rdata, src_rdata;

  assign in_stall_o  = !((state_q == S_IDLE) && !out_valid_q);
  assign in_acc      = in_valid_i && !in_stall_o;
  assign cfg_ready_o = 1'b1;
  assign out_valid_o = out_valid_q;
  assign potential_o = pot_out_q;
  assign status_o    = status_q;

  assign in_grid = (int'(pos_x_i) < GRID_X) && (int'(pos_y_i) < GRID_Y)
                && (int'(pos_z_i) < GRID_Z);
  assign wall    = (pos_z_i == 6'd0) || (int'(pos_z_i) == GRID_Z - 1);

  assign xp = (x_q == XW'(GRID_X - 1)) ? '0 : x_q + 1'b1;
  assign xm = (x_q == '0) ? XW'(GRID_X - 1) : x_q - 1'b1;
  assign yp = (y_q == YW'(GRID_Y - 1)) ? '0 : y_q + 1'b1;
  assign ym = (y_q == '0) ? YW'(GRID_Y - 1) : y_q - 1'b1;
  assign centre_addr = cell_addr(z_q, x_q, y_q);

  always_comb begin
    unique case (nb_q)
      NB_XP:   nb_addr = cell_addr(z_q, xp, y_q);
      NB_XM:   nb_addr = cell_addr(z_q, xm, y_q);
      NB_YP:   nb_addr = cell_addr(z_q, x_q, yp);
      NB_YM:   nb_addr = cell_addr(z_q, x_q, ym);
      NB_ZP:   nb_addr = cell_addr(z_q + 1'b1, x_q, y_q);
      NB_ZM:   nb_addr = cell_addr(z_q - 1'b1, x_q, y_q);
      default: nb_addr = centre_addr;
    endcase
  end

  always_comb begin
    logic [3:0] r4;
    div_d = div_q;
    rem_d = rem_q;
    for (int i = 0; i < DIV_BITS; i++) begin
      r4    = {rem_d, div_d[34]};
      div_d = {div_d[33:0], (r4 >= 4'd6)};
      rem_d = (r4 >= 4'd6) ? 3'(r4 - 4'd6) : r4[2:0];
    end
  end

  assign avg   = signed'(div_q[31:0] ^ 32'h8000_0000);
  assign resid = 34'(avg) - 34'(v_q) - 34'(s_q);
  assign new_v = sat32(64'(v_q) + 64'(prod_q >>> RELAX_SHIFT));

  always_comb begin
    pot_we    = 1'b0;
    pot_waddr = centre_addr;
    pot_wdata = new_v;
    src_we    = 1'b0;
    src_waddr = req_addr_q;
    src_wdata = sat32(64'(prodw_q >>> SOURCE_SHIFT));
    pot_raddr = (state_q == S_RD) ? req_addr_q : nb_addr;
    if (state_q == S_CLEAR) begin
      pot_we    = 1'b1;
      pot_waddr = clr_q;
      pot_wdata = '0;
      src_we    = 1'b1;
      src_waddr = clr_q;
      src_wdata = '0;
    end else if (state_q == S_UPD) begin
      pot_we = 1'b1;
    end else if (state_q == S_WR3) begin
      src_we = 1'b1;
    end
  end

  psor_ram #(.WIDTH(32), .DEPTH(CELLS)) u_pot_ram (
    .clk_i   (clk_i),
    .we_i    (pot_we),
    .waddr_i (pot_waddr),
    .wdata_i (pot_wdata),
    .raddr_i (pot_raddr),
    .rdata_o (pot_rdata)
  );

  psor_ram #(.WIDTH(32), .DEPTH(CELLS)) u_src_ram (
    .clk_i   (clk_i),
    .we_i    (src_we),
    .waddr_i (src_waddr),
    .wdata_i (src_wdata),
    .raddr_i (centre_addr),
    .rdata_o (src_rdata)
  );

  always_comb begin
    state_d = state_q;
    unique case (state_q)
      S_CLEAR: if (clr_q == AW'(CELLS - 1)) state_d = S_IDLE;
      S_IDLE: begin
        if (in_acc) begin
          if (operation_i == OP_WRITE && in_grid && !wall) begin
            state_d = S_WR1;
          end else if (operation_i == OP_READ && in_grid) begin
            state_d = S_RD;
          end else if (operation_i == OP_SOLVE && sweeps_q != 8'd0) begin
            state_d = S_SRD;
          end
        end
      end
      S_WR1:  state_d = S_WR2;
      S_WR2:  state_d = S_WR3;
      S_WR3:  state_d = S_IDLE;
      S_RD:   state_d = S_RDW;
      S_RDW:  state_d = S_IDLE;
      S_SRD:  if (nb_q == NB_LAST) state_d = S_DIV;
      S_DIV:  if (dstep_q == 3'(DIV_STEPS - 1)) state_d = S_MUL;
      S_MUL:  state_d = S_UPD;
      S_UPD: begin
        state_d = S_SRD;
        if (y_q == YW'(GRID_Y - 1) && x_q == XW'(GRID_X - 1)
            && z_q == ZW'(GRID_Z - 2) && sweep_q == sweeps_q - 8'd1) begin
          state_d = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_CLEAR;
      clr_q       <= '0;
      relax_q     <= RELAX_RESET;
      sweeps_q    <= SWEEPS_RESET;
      gain_q      <= GAIN_RESET;
      out_valid_q <= 1'b0;
      sweep_q     <= '0;
      z_q         <= ZW'(1);
      x_q         <= '0;
      y_q         <= '0;
      nb_q        <= '0;
      dstep_q     <= '0;
    end else begin
      state_q <= state_d;
      if (state_q == S_CLEAR) begin
        clr_q <= clr_q + 1'b1;
      end
      if (cfg_valid_i) begin
        case (cfg_index_i)
          REG_RELAX:  relax_q  <= cfg_data_i[14:0];
          REG_SWEEPS: sweeps_q <= cfg_data_i[7:0];
          REG_GAIN:   gain_q   <= signed'(cfg_data_i);
          default:    ;
        endcase
      end
      if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
      if (state_q == S_IDLE && in_acc) begin
        sweep_q <= '0;
        z_q     <= ZW'(1);
        x_q     <= '0;
        y_q     <= '0;
        nb_q    <= '0;
        if (state_d == S_IDLE) begin
          out_valid_q <= 1'b1;
        end
      end
      if (state_q == S_WR3 || state_q == S_RDW) begin
        out_valid_q <= 1'b1;
      end
      if (state_q == S_SRD) begin
        nb_q    <= nb_q + 1'b1;
        dstep_q <= '0;
      end
      if (state_q == S_DIV) begin
        dstep_q <= dstep_q + 1'b1;
      end
      if (state_q == S_UPD) begin
        nb_q <= '0;
        if (y_q == YW'(GRID_Y - 1)) begin
          y_q <= '0;
          if (x_q == XW'(GRID_X - 1)) begin
            x_q <= '0;
            if (z_q == ZW'(GRID_Z - 2)) begin
              z_q     <= ZW'(1);
              sweep_q <= sweep_q + 1'b1;
            end else begin
              z_q <= z_q + 1'b1;
            end
          end else begin
            x_q <= x_q + 1'b1;
          end
        end else begin
          y_q <= y_q + 1'b1;
        end
        if (state_d == S_IDLE) begin
          out_valid_q <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (state_q == S_IDLE && in_acc) begin
      req_addr_q <= cell_addr(ZW'(pos_z_i), XW'(pos_x_i), YW'(pos_y_i));
      diff_q     <= signed'({1'b0, electron_density_i}) - signed'({1'b0, ion_density_i});
      pot_out_q  <= '0;
      status_q   <= (operation_i == OP_WRITE) && (!in_grid || wall);
    end
    if (state_q == S_WR1) begin
      prodw_q <= 65'(gain_q) * 65'(diff_q);
    end
    if (state_q == S_RDW) begin
      pot_out_q <= signed'(pot_rdata);
    end
    if (state_q == S_SRD) begin
      if (nb_q == NB_XP) begin
        sum_q <= '0;
      end else if (nb_q == NB_LAST) begin
        v_q   <= signed'(pot_rdata);
        s_q   <= signed'(src_rdata);
        div_q <= 35'(sum_q + 35'sh3_0000_0000);
        rem_q <= '0;
      end else if (nb_q != NB_LAST && nb_q != NB_XP && nb_q <= NB_C) begin
        sum_q <= sum_q + 35'(signed'(pot_rdata));
      end
    end
    if (state_q == S_DIV) begin
      div_q <= div_d;
      rem_q <= rem_d;
    end
    if (state_q == S_MUL) begin
      prod_q <= 50'(signed'({1'b0, relax_q})) * 50'(resid);
    end
    if (state_q == S_UPD && state_d == S_IDLE) begin
      pot_out_q <= '0;
    end
  end

endmodule
